### src/kwm_pkg.sv
package kwm_pkg;

  // fixed field widths of the channels
  localparam int ACTION_WIDTH     = 2;
  localparam int LIST_INDEX_WIDTH = 3;
  localparam int DATA_WIDTH       = 32;
  localparam int STATUS_WIDTH     = 2;

  // default sizing of the list store
  localparam int NUM_LISTS_DEFAULT   = 8;
  localparam int LIST_DEPTH_DEFAULT  = 16;
  localparam int VALUE_WIDTH_DEFAULT = 32;

  // action codes
  localparam logic [ACTION_WIDTH-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACTION_WIDTH-1:0] ACT_POP    = 2'd1;
  localparam logic [ACTION_WIDTH-1:0] ACT_CLEAR  = 2'd2;

  // status codes
  localparam logic [STATUS_WIDTH-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_DROPPED = 2'd2;

  // command broadcast from the controller to every list cell
  typedef struct packed {
    logic                        append;
    logic                        clear;
    logic                        advance;
    logic [LIST_INDEX_WIDTH-1:0] list_index;
  } cell_cmd_t;

endpackage

### src/kwm_req_if.sv
interface kwm_req_if;
  import kwm_pkg::*;

  logic                               valid;
  logic                               ready;
  logic        [ACTION_WIDTH-1:0]     action;
  logic        [LIST_INDEX_WIDTH-1:0] list_index;
  logic signed [DATA_WIDTH-1:0]       value;

  modport source (output valid, action, list_index, value, input ready);
  modport sink (input valid, action, list_index, value, output ready);
endinterface

### src/kwm_rsp_if.sv
interface kwm_rsp_if;
  import kwm_pkg::*;

  logic                               valid;
  logic                               ready;
  logic signed [DATA_WIDTH-1:0]       out_value;
  logic        [LIST_INDEX_WIDTH-1:0] source_list;
  logic        [STATUS_WIDTH-1:0]     status;

  modport source (output valid, out_value, source_list, status, input ready);
  modport sink (input valid, out_value, source_list, status, output ready);
endinterface

### src/kwm_ram.sv
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/kwm_cell.sv
module kwm_cell #(
  parameter int INDEX       = 0,
  parameter int NUM_LISTS   = kwm_pkg::NUM_LISTS_DEFAULT,
  parameter int LIST_DEPTH  = kwm_pkg::LIST_DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  kwm_pkg::cell_cmd_t             cmd,
  input  logic [VALUE_WIDTH-1:0]         value,
  input  logic [$clog2(NUM_LISTS)-1:0]   win_index,
  input  logic                           cand_in_valid,
  input  logic signed [VALUE_WIDTH-1:0]  cand_in_value,
  input  logic [$clog2(NUM_LISTS)-1:0]   cand_in_index,
  output logic                           cand_out_valid,
  output logic signed [VALUE_WIDTH-1:0]  cand_out_value,
  output logic [$clog2(NUM_LISTS)-1:0]   cand_out_index,
  output logic                           took
);
  import kwm_pkg::*;

  localparam int IW = $clog2(NUM_LISTS);
  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);

  logic [CW-1:0]                 tail;
  logic [CW-1:0]                 head;
  logic [VALUE_WIDTH-1:0]        rdata;
  logic signed [VALUE_WIDTH-1:0] head_value;
  logic                          head_valid;
  logic                          selected;
  logic                          full;
  logic                          do_append;
  logic                          do_advance;
  logic                          better;

  // append decode for this list
  assign selected  = (INDEX < (1 << LIST_INDEX_WIDTH)) &&
                     (cmd.list_index == LIST_INDEX_WIDTH'(INDEX));
  assign full      = (tail == CW'(LIST_DEPTH));
  assign do_append = cmd.append && selected && !full;
  assign took      = do_append;

  assign do_advance = cmd.advance && (win_index == IW'(INDEX));

  // list buffer, head entry read every cycle
  kwm_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (do_append),
    .waddr (tail[AW-1:0]),
    .wdata (value),
    .raddr (head[AW-1:0]),
    .rdata (rdata)
  );

  assign head_value = $signed(rdata);
  assign head_valid = (head < tail);

  // head and tail counters
  always_ff @(posedge clk) begin
    if (rst) begin
      tail <= '0;
      head <= '0;
    end else if (cmd.clear) begin
      tail <= '0;
      head <= '0;
    end else begin
      if (do_append) begin
        tail <= tail + CW'(1);
      end
      if (do_advance) begin
        head <= head + CW'(1);
      end
    end
  end

  // strict less keeps the lower index on a tie
  assign better = head_valid && (!cand_in_valid || (head_value < cand_in_value));

  // candidate stage handed to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out_valid <= 1'b0;
    end else begin
      cand_out_valid <= cand_in_valid || head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      cand_out_value <= head_value;
      cand_out_index <= IW'(INDEX);
    end else begin
      cand_out_value <= cand_in_value;
      cand_out_index <= cand_in_index;
    end
  end

endmodule

### src/k_way_sorted_merge.sv
// K-way merge of sorted lists. Each of NUM_LISTS lists lives in its own cell
// with a LIST_DEPTH-entry buffer; an append adds a value at a list's tail
// (status 2 when the list is full or the index is out of range), a pop
// returns the smallest head with ties going to the lower list, and a clear
// empties every list. One transaction is worked at a time: append, clear and
// the unused action code finish without waiting on the cells, while a pop
// waits for the candidate chain through which every cell compares its head
// against the best so far, one cell per cycle. A finished result waits in an
// output register while the next transaction is accepted.
module k_way_sorted_merge #(
  parameter int NUM_LISTS   = kwm_pkg::NUM_LISTS_DEFAULT,
  parameter int LIST_DEPTH  = kwm_pkg::LIST_DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  kwm_req_if.sink   req,
  kwm_rsp_if.source rsp
);
  import kwm_pkg::*;

  localparam int IW       = $clog2(NUM_LISTS);
  localparam int POP_LAST = NUM_LISTS + 1;
  localparam int CNT_W    = $clog2(POP_LAST + 1);

  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic [ACTION_WIDTH-1:0]     item_action;
  logic [LIST_INDEX_WIDTH-1:0] item_index;
  logic [VALUE_WIDTH-1:0]      item_value;

  logic                        accept;
  logic                        done;
  logic                        out_free;
  logic                        fire;
  cell_cmd_t                   cmd;

  logic                        cand_valid [NUM_LISTS+1];
  logic signed [VALUE_WIDTH-1:0] cand_value [NUM_LISTS+1];
  logic [IW-1:0]               cand_index [NUM_LISTS+1];
  logic [NUM_LISTS-1:0]        took;

  logic                        out_valid;
  logic signed [DATA_WIDTH-1:0] out_value;
  logic [LIST_INDEX_WIDTH-1:0] source_list;
  logic [STATUS_WIDTH-1:0]     status;

  // handshake and completion
  assign req.ready = !busy;
  assign accept    = req.valid && !busy;
  assign done      = (item_action == ACT_POP) ? (cnt == CNT_W'(POP_LAST)) : 1'b1;
  assign out_free  = !out_valid || rsp.ready;
  assign fire      = busy && done && out_free;

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (fire) begin
      busy <= 1'b0;
    end else if (busy && !done) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // transaction capture, value cut to the storage width
  always_ff @(posedge clk) begin
    if (accept) begin
      item_action <= req.action;
      item_index  <= req.list_index;
      item_value  <= VALUE_WIDTH'(req.value);
    end
  end

  // command to the cells, applied only at completion
  always_comb begin
    cmd.append     = fire && (item_action == ACT_APPEND);
    cmd.clear      = fire && (item_action == ACT_CLEAR);
    cmd.advance    = fire && (item_action == ACT_POP) && cand_valid[NUM_LISTS];
    cmd.list_index = item_index;
  end

  // head of the candidate chain carries nothing
  assign cand_valid[0] = 1'b0;
  assign cand_value[0] = '0;
  assign cand_index[0] = '0;

  // row of list cells
  for (genvar g = 0; g < NUM_LISTS; g++) begin : g_cell
    kwm_cell #(
      .INDEX       (g),
      .NUM_LISTS   (NUM_LISTS),
      .LIST_DEPTH  (LIST_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .cmd            (cmd),
      .value          (item_value),
      .win_index      (cand_index[NUM_LISTS]),
      .cand_in_valid  (cand_valid[g]),
      .cand_in_value  (cand_value[g]),
      .cand_in_index  (cand_index[g]),
      .cand_out_valid (cand_valid[g+1]),
      .cand_out_value (cand_value[g+1]),
      .cand_out_index (cand_index[g+1]),
      .took           (took[g])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      case (item_action)
        ACT_APPEND: begin
          out_value   <= '0;
          source_list <= '0;
          status      <= (|took) ? ST_OK : ST_DROPPED;
        end
        ACT_POP: begin
          if (cand_valid[NUM_LISTS]) begin
            out_value   <= DATA_WIDTH'(cand_value[NUM_LISTS]);
            source_list <= LIST_INDEX_WIDTH'(cand_index[NUM_LISTS]);
            status      <= ST_OK;
          end else begin
            out_value   <= '0;
            source_list <= '0;
            status      <= ST_EMPTY;
          end
        end
        default: begin
          out_value   <= '0;
          source_list <= '0;
          status      <= ST_OK;
        end
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.out_value   = out_value;
  assign rsp.source_list = source_list;
  assign rsp.status      = status;

endmodule

### src/kwm_checker.sv
module kwm_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 req_valid,
  input logic                                 req_ready,
  input logic                                 rsp_valid,
  input logic                                 rsp_ready,
  input logic signed [kwm_pkg::DATA_WIDTH-1:0] rsp_out_value,
  input logic [kwm_pkg::LIST_INDEX_WIDTH-1:0] rsp_source_list,
  input logic [kwm_pkg::STATUS_WIDTH-1:0]     rsp_status
);

  // one transaction in flight: ready drops after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("input accepted while a transaction is still in flight");

  // a new result only appears at the end of a transaction's work
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("result appeared without a transaction in progress");

  // stalled result stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      $stable(rsp_out_value) && $stable(rsp_source_list) && $stable(rsp_status))
    else $error("result payload changed while stalled");

endmodule

bind k_way_sorted_merge kwm_checker u_kwm_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_out_value   (rsp.out_value),
  .rsp_source_list (rsp.source_list),
  .rsp_status      (rsp.status)
);

### tb/k_way_sorted_merge_test.sv
module k_way_sorted_merge_test;
  import kwm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLISTS = NUM_LISTS_DEFAULT;
  localparam int DEPTH  = LIST_DEPTH_DEFAULT;

  // action code with no function in the block
  localparam logic [ACTION_WIDTH-1:0] ACT_UNUSED = 2'd3;

  localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [ACTION_WIDTH-1:0]     action;
    logic [LIST_INDEX_WIDTH-1:0] list_index;
    logic signed [DATA_WIDTH-1:0] value;
  } merge_cmd_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] out_value;
    logic [LIST_INDEX_WIDTH-1:0]  source_list;
    logic [STATUS_WIDTH-1:0]      status;
  } merge_result_t;

  logic clk;
  logic rst;

  kwm_req_if req_bus ();
  kwm_rsp_if rsp_bus ();

  k_way_sorted_merge u_top (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // commands waiting to be driven, results waiting to come back
  merge_cmd_t    cmd_queue[$];
  merge_result_t merge_expected[$];

  // shadow of the list store
  logic signed [DATA_WIDTH-1:0] list_mem [NLISTS][DEPTH];
  int list_tail [NLISTS];
  int list_head [NLISTS];

  // stimulus generator state: last sorted value handed to each list
  logic signed [DATA_WIDTH-1:0] gen_last [NLISTS];
  bit gen_started [NLISTS];
  int gen_count;

  int gap_pct;
  int stall_pct;
  int mismatch_count;
  logic req_taken;
  merge_cmd_t drive_cmd;
  merge_result_t got_result;
  merge_result_t want_result;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("k_way_sorted_merge: mismatch");
    $finish;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    if (mismatch_count <= 30) begin
      $display("%0t error %s: got %0d expected %0d", $realtime, what, got, want);
    end
  endtask

  // expected result of one command, updating the shadow lists
  function automatic merge_result_t merge_predict(merge_cmd_t c);
    merge_result_t r;
    int best;
    int idx;
    logic signed [DATA_WIDTH-1:0] best_v;
    r = '0;
    best = -1;
    best_v = '0;
    idx = int'(c.list_index);
    case (c.action)
      ACT_APPEND: begin
        if (idx >= NLISTS || list_tail[idx] >= DEPTH) begin
          r.status = ST_DROPPED;
        end else begin
          list_mem[idx][list_tail[idx]] = c.value;
          list_tail[idx]++;
        end
      end
      ACT_POP: begin
        // smallest head, strict compare keeps the lower list on a tie
        for (int i = 0; i < NLISTS; i++) begin
          if (list_head[i] < list_tail[i] &&
              (best < 0 || list_mem[i][list_head[i]] < best_v)) begin
            best = i;
            best_v = list_mem[i][list_head[i]];
          end
        end
        if (best < 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_value = best_v;
          r.source_list = LIST_INDEX_WIDTH'(best);
          list_head[best]++;
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < NLISTS; i++) begin
          list_tail[i] = 0;
          list_head[i] = 0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_item(logic [ACTION_WIDTH-1:0] act, logic [LIST_INDEX_WIDTH-1:0] idx,
                          logic signed [DATA_WIDTH-1:0] val);
    merge_cmd_t c;
    c.action = act;
    c.list_index = idx;
    c.value = val;
    cmd_queue = {cmd_queue, c};
    gen_count++;
    if (act == ACT_CLEAR) begin
      for (int i = 0; i < NLISTS; i++) gen_started[i] = 1'b0;
    end
  endtask

  // next value of an ascending run on list l
  function automatic logic signed [DATA_WIDTH-1:0] next_sorted(int l, int step_max);
    longint nxt;
    if (!gen_started[l]) begin
      case ($urandom_range(0, 4))
        0: nxt = longint'($signed($urandom()));
        1: nxt = longint'($urandom_range(0, 3));
        2: nxt = longint'($urandom_range(0, 200)) - 100;
        3: nxt = longint'(VAL_MIN) + $urandom_range(0, 50);
        default: nxt = longint'(VAL_MAX) - $urandom_range(0, 50);
      endcase
    end else begin
      nxt = longint'(gen_last[l]) + longint'($urandom_range(0, step_max));
    end
    if (nxt > longint'(VAL_MAX)) nxt = longint'(VAL_MAX);
    gen_last[l] = DATA_WIDTH'(nxt);
    gen_started[l] = 1'b1;
    return gen_last[l];
  endfunction

  // mostly sorted merge runs, with noise and unsorted runs mixed in
  task automatic fill_random(int count);
    int stop_at;
    int kind;
    int n_app;
    int n_pop;
    int hot;
    int step;
    int l;
    stop_at = gen_count + count;
    while (gen_count < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        n_app = $urandom_range(1, 24);
        hot = ($urandom_range(0, 2) == 0) ? $urandom_range(0, NLISTS - 1) : -1;
        case ($urandom_range(0, 3))
          0: step = 0;
          1: step = 3;
          2: step = 1000;
          default: step = 1 << 24;
        endcase
        for (int i = 0; i < n_app; i++) begin
          l = (hot >= 0) ? hot : $urandom_range(0, NLISTS - 1);
          add_item(ACT_APPEND, LIST_INDEX_WIDTH'(l), next_sorted(l, step));
          if ($urandom_range(0, 6) == 0) add_item(ACT_POP, '0, '0);
        end
        n_pop = ($urandom_range(0, 3) == 0) ? n_app / 2 : n_app + $urandom_range(0, 2);
        for (int i = 0; i < n_pop; i++) add_item(ACT_POP, '0, '0);
        if ($urandom_range(0, 1) == 0) add_item(ACT_CLEAR, '0, '0);
      end else if (kind < 85) begin
        n_app = $urandom_range(1, 8);
        for (int i = 0; i < n_app; i++) begin
          add_item(ACTION_WIDTH'($urandom_range(0, 3)), LIST_INDEX_WIDTH'($urandom()),
                   $signed($urandom()));
        end
      end else begin
        n_app = $urandom_range(1, 12);
        for (int i = 0; i < n_app; i++) begin
          add_item(ACT_APPEND, LIST_INDEX_WIDTH'($urandom()), $signed($urandom()));
        end
        for (int i = 0; i < n_app; i++) add_item(ACT_POP, '0, '0);
      end
    end
  endtask

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || req_bus.valid || merge_expected.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // driver: new command at the falling edge once the last one was taken
  always @(negedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
      req_bus.action <= ACT_APPEND;
      req_bus.list_index <= '0;
      req_bus.value <= '0;
    end else if (!req_bus.valid || req_taken) begin
      if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        drive_cmd = cmd_queue.pop_front();
        req_bus.valid <= 1'b1;
        req_bus.action <= drive_cmd.action;
        req_bus.list_index <= drive_cmd.list_index;
        req_bus.value <= drive_cmd.value;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor: predict on accepted commands, check accepted results
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_bus.valid && req_bus.ready;
      if (req_bus.valid && req_bus.ready) begin
        merge_expected = {merge_expected, merge_predict({req_bus.action,
                                                         req_bus.list_index,
                                                         req_bus.value})};
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        got_result = {rsp_bus.out_value, rsp_bus.source_list, rsp_bus.status};
        if (merge_expected.size() == 0) begin
          report_mismatch("result with no transaction pending", got_result.out_value, 0);
        end else begin
          want_result = merge_expected.pop_front();
          if (got_result.out_value !== want_result.out_value)
            report_mismatch("out_value", got_result.out_value, want_result.out_value);
          if (got_result.source_list !== want_result.source_list)
            report_mismatch("source_list", got_result.source_list, want_result.source_list);
          if (got_result.status !== want_result.status)
            report_mismatch("status", got_result.status, want_result.status);
        end
      end
    end
  end

  // stimulus sequencing
  initial begin
    gap_pct = 0;
    stall_pct = 0;
    mismatch_count = 0;
    gen_count = 0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty pop, extreme values, ties, unused code, clear
    add_item(ACT_POP, 3'd5, VAL_MAX);
    add_item(ACT_APPEND, 3'd0, VAL_MIN);
    add_item(ACT_APPEND, 3'd7, VAL_MAX);
    add_item(ACT_APPEND, 3'd3, -32'sd1);
    add_item(ACT_APPEND, 3'd3, 32'sd0);
    add_item(ACT_APPEND, 3'd2, 32'sd5);
    add_item(ACT_APPEND, 3'd1, 32'sd5);
    add_item(ACT_APPEND, 3'd6, 32'sh5555_5555);
    add_item(ACT_UNUSED, 3'd7, VAL_MIN);
    add_item(ACT_POP, '0, '0);
    add_item(ACT_POP, '0, '0);
    add_item(ACT_POP, '0, '0);
    add_item(ACT_POP, '0, '0);
    add_item(ACT_POP, '0, '0);
    add_item(ACT_POP, '0, '0);
    add_item(ACT_POP, '0, '0);
    add_item(ACT_POP, '0, '0);
    add_item(ACT_APPEND, 3'd4, 32'shAAAA_AAAA);
    add_item(ACT_CLEAR, 3'd4, VAL_MAX);
    add_item(ACT_POP, '0, '0);

    // no idling
    fill_random(280);
    wait_drained();

    // sender idle, with a full drain before it starts
    gap_pct = 66;
    fill_random(285);
    wait_drained();

    // receiver stalling
    gap_pct = 0;
    stall_pct = 66;
    fill_random(285);
    wait_drained();

    // both sides idling
    gap_pct = 32;
    stall_pct = 32;
    fill_random(285);
    wait_drained();

    repeat (30) @(posedge clk);
    if (merge_expected.size() != 0)
      report_mismatch("results never returned", 0, merge_expected.size());
    if (mismatch_count == 0) begin
      $display("k_way_sorted_merge: match");
    end else begin
      $display("k_way_sorted_merge: mismatch");
    end
    $finish;
  end

endmodule
